// ----- src/amm_pkg.sv -----
package amm_pkg;

  // Fixed field widths and arithmetic formats.
  localparam int SAMPLE_BITS    = 24;
  localparam int GAIN_BITS      = 16;
  localparam int GAIN_FRAC_BITS = 12;
  localparam int ACC_BITS       = 48;
  localparam int PROD_BITS      = SAMPLE_BITS + GAIN_BITS;
  localparam int SHIFT_BITS     = ACC_BITS + 1 - GAIN_FRAC_BITS;
  localparam int SRC_W          = 3;
  localparam int SNK_W          = 3;
  localparam int CFG_W          = 4;
  localparam int CFG_IDX_W      = 2;

  // Half an output step, added before the floor shift to round to nearest.
  localparam logic [ACC_BITS:0] ROUND_HALF = (ACC_BITS + 1)'(1) << (GAIN_FRAC_BITS - 1);

  // Request codes.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_GAIN   = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_SOURCES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_SINKS   = 2'd1;

  typedef struct packed {
    logic                          cmd;
    logic [SRC_W-1:0]              source_index;
    logic [SNK_W-1:0]              sink_index;
    logic signed [GAIN_BITS-1:0]   gain_value;
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic                          frame_end;
  } in_item_t;

  typedef struct packed {
    logic [SNK_W-1:0]              out_sink;
    logic signed [SAMPLE_BITS-1:0] out_sample;
    logic                          last_of_run;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_MAC     = 5'b00010,
    ST_DRAIN   = 5'b00100,
    ST_EMIT_RD = 5'b01000,
    ST_EMIT_LD = 5'b10000
  } state_e;

endpackage

// ----- src/amm_ram.sv -----
module amm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/audio_matrix_mixer.sv -----
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_stall_o    in_data_i  (amm_pkg::in_item_t)
// out       output     out_valid_o / out_stall_i  out_data_o (amm_pkg::out_item_t)
// cfg       input      cfg_we_i                   cfg_idx_i, cfg_data_i
//
// A gain write does not stall the input. A sample item of an active source
// stalls the input once taken, while N active sinks are walked one per cycle
// through the read-multiply-write pipeline and the pipeline then drains.
// A frame end then adds an emit walk with one accumulator read per sink result.
// Reset clears the gain valid bits and accumulator valid bits at once, so no
// clearing pass is needed. A stalled output holds the block in its emit phase.
module audio_matrix_mixer #(
  parameter int MAX_SOURCES = 8,
  parameter int MAX_SINKS   = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  amm_pkg::in_item_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output amm_pkg::out_item_t                  out_data_o,
  input  logic                                cfg_we_i,
  input  logic [amm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [amm_pkg::CFG_W-1:0]           cfg_data_i
);

  // Only rows and columns reachable by the 3-bit indexes are stored. Columns
  // beyond that are never written, so their gain is always zero.
  localparam int Rows      = (MAX_SOURCES < 8) ? MAX_SOURCES : 8;
  localparam int Cols      = (MAX_SINKS < 8) ? MAX_SINKS : 8;
  localparam int GainDepth = Rows * Cols;
  localparam int GaW       = (GainDepth > 1) ? $clog2(GainDepth) : 1;
  localparam int KW        = (MAX_SINKS > 1) ? $clog2(MAX_SINKS) : 1;
  localparam int SnkCntW   = ($clog2(MAX_SINKS + 1) > amm_pkg::CFG_W) ?
                             $clog2(MAX_SINKS + 1) : amm_pkg::CFG_W;
  localparam int SrcCntW   = ($clog2(MAX_SOURCES + 1) > amm_pkg::CFG_W) ?
                             $clog2(MAX_SOURCES + 1) : amm_pkg::CFG_W;

  amm_pkg::state_e state_q, state_d;

  logic [amm_pkg::CFG_W-1:0] act_src_q, act_snk_q;
  logic [SrcCntW-1:0]        src_cnt;
  logic [SnkCntW-1:0]        snk_cnt;

  // Latched sample request.
  logic [amm_pkg::SRC_W-1:0]              src_q;
  logic signed [amm_pkg::SAMPLE_BITS-1:0] sample_q;
  logic                                   frame_q;

  // Sink counter shared by the accumulate walk and the emit walk.
  logic [SnkCntW-1:0] k_q, k_d;
  logic               k_last;

  logic in_acc, is_gain, src_active;

  // Gain memory.
  logic [GainDepth-1:0]             gain_vld_q;
  logic                             gain_we;
  logic [GaW-1:0]                   gain_waddr, gain_raddr;
  logic [amm_pkg::GAIN_BITS-1:0]    gain_rdata;
  logic                             gain_col_ok;

  // Accumulator memory.
  logic [MAX_SINKS-1:0]             acc_vld_q;
  logic                             acc_clr;
  logic [KW-1:0]                    acc_raddr;
  logic [amm_pkg::ACC_BITS-1:0]     acc_rdata;

  // Pipeline stages of the multiply-accumulate walk.
  logic                                 s1_vld_q, s1_aok_q, s1_gok_q;
  logic [KW-1:0]                        s1_k_q;
  logic                                 s2_vld_q;
  logic [KW-1:0]                        s2_k_q;
  logic signed [amm_pkg::ACC_BITS-1:0]  s2_acc_q;
  logic signed [amm_pkg::PROD_BITS-1:0] s2_prod_q;
  logic signed [amm_pkg::GAIN_BITS-1:0] gain_s1;
  logic signed [amm_pkg::PROD_BITS-1:0] prod;
  logic [amm_pkg::ACC_BITS:0]           sum;
  logic [amm_pkg::ACC_BITS-1:0]         sum_sat;

  // Output rounding and the output register.
  logic [amm_pkg::ACC_BITS-1:0]      eacc;
  logic [amm_pkg::ACC_BITS:0]        rnd;
  logic [amm_pkg::SHIFT_BITS-1:0]    shifted;
  logic [amm_pkg::SHIFT_BITS-amm_pkg::SAMPLE_BITS:0] hi_bits;
  logic [amm_pkg::SAMPLE_BITS-1:0]   res_sample;
  logic                              out_vld_q, out_free, out_load;
  amm_pkg::out_item_t                out_q;

  // Counts above the built maximum act as the maximum.
  assign src_cnt = (SrcCntW'(act_src_q) > SrcCntW'(MAX_SOURCES)) ?
                   SrcCntW'(MAX_SOURCES) : SrcCntW'(act_src_q);
  assign snk_cnt = (SnkCntW'(act_snk_q) > SnkCntW'(MAX_SINKS)) ?
                   SnkCntW'(MAX_SINKS) : SnkCntW'(act_snk_q);

  assign in_stall_o = (state_q != amm_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == amm_pkg::ST_IDLE);
  assign is_gain    = (in_data_i.cmd == amm_pkg::CMD_GAIN);
  assign src_active = (SrcCntW'(in_data_i.source_index) < src_cnt);
  assign k_last     = ((k_q + SnkCntW'(1)) == snk_cnt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_src_q <= amm_pkg::CFG_W'(8);
      act_snk_q <= amm_pkg::CFG_W'(8);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == amm_pkg::CFG_ACTIVE_SOURCES) begin
        act_src_q <= cfg_data_i;
      end else if (cfg_idx_i == amm_pkg::CFG_ACTIVE_SINKS) begin
        act_snk_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && !is_gain) begin
      src_q    <= in_data_i.source_index;
      sample_q <= in_data_i.sample_value;
      frame_q  <= in_data_i.frame_end;
    end
  end

  // Sequencer: accumulate walk, pipeline drain, then the emit walk on a
  // frame end.
  always_comb begin
    state_d  = state_q;
    k_d      = k_q;
    acc_clr  = 1'b0;
    out_load = 1'b0;
    case (state_q)
      amm_pkg::ST_IDLE: begin
        if (in_acc && !is_gain) begin
          k_d = '0;
          if (src_active && (snk_cnt != '0)) begin
            state_d = amm_pkg::ST_MAC;
          end else if (in_data_i.frame_end) begin
            if (snk_cnt != '0) begin
              state_d = amm_pkg::ST_EMIT_RD;
            end else begin
              acc_clr = 1'b1;
            end
          end
        end
      end
      amm_pkg::ST_MAC: begin
        k_d = k_q + SnkCntW'(1);
        if (k_last) begin
          state_d = amm_pkg::ST_DRAIN;
        end
      end
      amm_pkg::ST_DRAIN: begin
        if (!s1_vld_q && !s2_vld_q) begin
          k_d     = '0;
          state_d = frame_q ? amm_pkg::ST_EMIT_RD : amm_pkg::ST_IDLE;
        end
      end
      amm_pkg::ST_EMIT_RD: begin
        state_d = amm_pkg::ST_EMIT_LD;
      end
      amm_pkg::ST_EMIT_LD: begin
        if (out_free) begin
          out_load = 1'b1;
          if (k_last) begin
            acc_clr = 1'b1;
            state_d = amm_pkg::ST_IDLE;
          end else begin
            k_d     = k_q + SnkCntW'(1);
            state_d = amm_pkg::ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = amm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= amm_pkg::ST_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  // Gain table: written straight from a gain request, read by the walk.
  assign gain_we = in_acc && is_gain && (int'(in_data_i.source_index) < Rows) &&
                   (int'(in_data_i.sink_index) < Cols);
  assign gain_waddr = GaW'(int'(in_data_i.source_index) * Cols +
                           int'(in_data_i.sink_index));
  assign gain_raddr  = GaW'(int'(src_q) * Cols + int'(k_q));
  assign gain_col_ok = (int'(k_q) < Cols);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_vld_q <= '0;
    end else if (gain_we) begin
      gain_vld_q[gain_waddr] <= 1'b1;
    end
  end

  amm_ram #(
    .WIDTH(amm_pkg::GAIN_BITS),
    .DEPTH(GainDepth)
  ) u_gain_ram (
    .clk_i  (clk_i),
    .we_i   (gain_we),
    .waddr_i(gain_waddr),
    .wdata_i(in_data_i.gain_value),
    .raddr_i(gain_raddr),
    .rdata_o(gain_rdata)
  );

  // Accumulators: an entry whose valid bit is clear reads as zero, so a
  // frame end clears them all at once.
  assign acc_raddr = k_q[KW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_vld_q <= '0;
    end else if (acc_clr) begin
      acc_vld_q <= '0;
    end else if (s2_vld_q) begin
      acc_vld_q[s2_k_q] <= 1'b1;
    end
  end

  amm_ram #(
    .WIDTH(amm_pkg::ACC_BITS),
    .DEPTH(MAX_SINKS)
  ) u_acc_ram (
    .clk_i  (clk_i),
    .we_i   (s2_vld_q),
    .waddr_i(s2_k_q),
    .wdata_i(sum_sat),
    .raddr_i(acc_raddr),
    .rdata_o(acc_rdata)
  );

  // Stage one: memory data arrives, multiply. Stage two: add, saturate and
  // write back. The walk touches each sink once, so the write-back of an earlier
  // sink never hits the entry being read.
  assign gain_s1 = s1_gok_q ? $signed(gain_rdata) : '0;
  assign prod    = sample_q * gain_s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= (state_q == amm_pkg::ST_MAC);
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_k_q    <= k_q[KW-1:0];
    s1_aok_q  <= acc_vld_q[acc_raddr];
    s1_gok_q  <= gain_col_ok && gain_vld_q[gain_raddr];
    s2_k_q    <= s1_k_q;
    s2_acc_q  <= s1_aok_q ? $signed(acc_rdata) : '0;
    s2_prod_q <= prod;
  end

  assign sum = {s2_acc_q[amm_pkg::ACC_BITS-1], s2_acc_q} +
               {{(amm_pkg::ACC_BITS + 1 - amm_pkg::PROD_BITS){s2_prod_q[amm_pkg::PROD_BITS-1]}},
                s2_prod_q};

  // The accumulator sticks at the 48-bit limits when a long frame overflows.
  always_comb begin
    if (sum[amm_pkg::ACC_BITS] != sum[amm_pkg::ACC_BITS-1]) begin
      sum_sat = {sum[amm_pkg::ACC_BITS], {(amm_pkg::ACC_BITS - 1){~sum[amm_pkg::ACC_BITS]}}};
    end else begin
      sum_sat = sum[amm_pkg::ACC_BITS-1:0];
    end
  end

  // Round to nearest with ties toward plus infinity, floor shift, then
  // saturate to the sample range.
  assign eacc    = s1_aok_q ? acc_rdata : '0;
  assign rnd     = {eacc[amm_pkg::ACC_BITS-1], eacc} + amm_pkg::ROUND_HALF;
  assign shifted = rnd[amm_pkg::ACC_BITS:amm_pkg::GAIN_FRAC_BITS];
  assign hi_bits = shifted[amm_pkg::SHIFT_BITS-1:amm_pkg::SAMPLE_BITS-1];

  always_comb begin
    if (&hi_bits || ~|hi_bits) begin
      res_sample = shifted[amm_pkg::SAMPLE_BITS-1:0];
    end else begin
      res_sample = {hi_bits[amm_pkg::SHIFT_BITS-amm_pkg::SAMPLE_BITS],
                    {(amm_pkg::SAMPLE_BITS - 1){~hi_bits[amm_pkg::SHIFT_BITS-amm_pkg::SAMPLE_BITS]}}};
    end
  end

  // The output register lets the last result of a frame wait while new
  // requests are taken.
  assign out_free = !out_vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.out_sink    <= amm_pkg::SNK_W'(k_q);
      out_q.out_sample  <= res_sample;
      out_q.last_of_run <= k_last;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // The write-back of the walk never targets the entry read in that cycle.
  a_mac_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_vld_q && (state_q == amm_pkg::ST_MAC)) |-> (s2_k_q != acc_raddr))
    else $error("accumulator write overlaps read");

  // No accumulate work is left in flight once the block takes requests.
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == amm_pkg::ST_IDLE) |-> (!s1_vld_q && !s2_vld_q))
    else $error("pipeline busy while idle");

  // A result appears only from the emit walk.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == amm_pkg::ST_EMIT_LD))
    else $error("result loaded outside emit");

  // The last result of a frame leaves all accumulators cleared.
  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && k_last) |=> (acc_vld_q == '0))
    else $error("accumulators not cleared after frame");

endmodule

// ----- tb/sv/amm_tb_pkg.sv -----
`timescale 1ns / 100ps

package amm_tb_pkg;
  import amm_pkg::*;

  localparam int MIX_SOURCES = 8;
  localparam int MIX_SINKS   = 8;

  localparam logic [CFG_W-1:0] RESET_ACTIVE = 4'd8;

  // Register indexes that the block does not decode.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

  // Keeps its own copy of the gain matrix, the sink accumulators and the two
  // channel counts, and queues the sink samples that each request produces.
  class sink_mix_board;
    logic signed [GAIN_BITS-1:0] gain_tab [MIX_SOURCES][MIX_SINKS];
    longint                      sink_acc [MIX_SINKS];
    logic [CFG_W-1:0]            n_sources;
    logic [CFG_W-1:0]            n_sinks;
    out_item_t                   expected_mix [$];
    int                          mismatches;

    function new();
      foreach (gain_tab[i, j]) gain_tab[i][j] = '0;
      foreach (sink_acc[k]) sink_acc[k] = 0;
      n_sources  = RESET_ACTIVE;
      n_sinks    = RESET_ACTIVE;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == CFG_ACTIVE_SOURCES) begin
        n_sources = val;
      end else if (idx == CFG_ACTIVE_SINKS) begin
        n_sinks = val;
      end
    endfunction

    function int live_sources();
      return (n_sources > MIX_SOURCES) ? MIX_SOURCES : int'(n_sources);
    endfunction

    function int live_sinks();
      return (n_sinks > MIX_SINKS) ? MIX_SINKS : int'(n_sinks);
    endfunction

    function longint clip(longint v, int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) << (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    function void take_request(in_item_t req);
      int        nsrc;
      int        nsnk;
      longint    smp;
      longint    gn;
      longint    mixed;
      out_item_t res;
      nsrc = live_sources();
      nsnk = live_sinks();
      if (req.cmd == CMD_GAIN) begin
        gain_tab[req.source_index][req.sink_index] = req.gain_value;
        return;
      end
      if (int'(req.source_index) < nsrc) begin
        smp = $signed(req.sample_value);
        for (int k = 0; k < nsnk; k++) begin
          gn          = $signed(gain_tab[req.source_index][k]);
          sink_acc[k] = clip(sink_acc[k] + smp * gn, ACC_BITS);
        end
      end
      if (req.frame_end) begin
        for (int k = 0; k < nsnk; k++) begin
          mixed           = (sink_acc[k] + (longint'(1) << (GAIN_FRAC_BITS - 1)))
                            >>> GAIN_FRAC_BITS;
          mixed           = clip(mixed, SAMPLE_BITS);
          res.out_sink    = k[SNK_W-1:0];
          res.out_sample  = mixed[SAMPLE_BITS-1:0];
          res.last_of_run = (k == nsnk - 1);
          expected_mix.push_back(res);
        end
        foreach (sink_acc[k]) sink_acc[k] = 0;
      end
    endfunction

    function void match_result(out_item_t got);
      out_item_t want;
      if (expected_mix.size() == 0) begin
        $error("unexpected result: out_sink %0d out_sample %0d last_of_run %0b",
               got.out_sink, $signed(got.out_sample), got.last_of_run);
        mismatches++;
        return;
      end
      want = expected_mix.pop_front();
      if (got.out_sink !== want.out_sink) begin
        $error("out_sink: expected %0d, actual %0d", want.out_sink, got.out_sink);
        mismatches++;
      end
      if (got.out_sample !== want.out_sample) begin
        $error("out_sample: expected %0d, actual %0d",
               $signed(want.out_sample), $signed(got.out_sample));
        mismatches++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $error("last_of_run: expected %0b, actual %0b", want.last_of_run, got.last_of_run);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_mix.size();
    endfunction
  endclass

endpackage

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import amm_pkg::*;
  import amm_tb_pkg::*;

  // Cycles allowed after the last expected sink sample before the block is
  // treated as idle. This leaves a wide margin for the trailing MAC work of a
  // sample of an active source.
  localparam int SETTLE_CYCLES = 40;

  // Long enough to overflow a 48-bit accumulator with the largest products.
  localparam int OVERFLOW_SAMPLES = 530;

  localparam int RANDOM_PHASES    = 6;
  localparam int ITEMS_PER_PHASE  = 8;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  in_item_t           in_data_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  out_item_t          out_data_o;
  logic               cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]   cfg_data_i  = '0;

  // When set, neither side inserts idle cycles any more.
  bit calm = 1'b0;
  int stall_run = 0;

  sink_mix_board board = new();

  audio_matrix_mixer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // The receiver alternates between stall bursts and free stretches of random
  // length, so stalls land on every emit position.
  always @(posedge clk_i) begin
    if (calm) begin
      out_stall_i <= 1'b0;
    end else if (stall_run == 0) begin
      if (out_stall_i) begin
        out_stall_i <= 1'b0;
        stall_run = $urandom_range(0, 39);
      end else begin
        out_stall_i <= 1'b1;
        stall_run = $urandom_range(0, 18);
      end
    end else begin
      stall_run--;
    end
  end

  // Every sink sample taken by the receiver is checked against the oldest
  // expectation. Values are sampled before this edge's updates land.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.match_result(out_data_o);
    end
  end

  // Presents one request and holds it until the block takes it. Must be
  // called at a rising edge; it returns at the edge that accepted it.
  task automatic send_request(in_item_t req);
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    board.take_request(req);
  endtask

  task automatic hold_off(int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // A random gap ahead of a request, unless the run is in its calm tail.
  task automatic offer(in_item_t req);
    if (!calm && $urandom_range(0, 4) == 0) begin
      hold_off($urandom_range(1, 19));
    end
    send_request(req);
  endtask

  // The sender waits until every expected sink sample has come out, then
  // lets trailing MAC work finish, so the block is idle afterwards.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // The enable is lowered after each write, before the task returns, so that the
  // next write never raises it in the same step.
  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    board.write_reg(idx, val);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_counts(logic [CFG_W-1:0] sources, logic [CFG_W-1:0] sinks);
    set_reg(CFG_ACTIVE_SOURCES, sources);
    set_reg(CFG_ACTIVE_SINKS, sinks);
  endtask

  // Fields that a request does not use are filled with random bits, so that
  // every bit of every field toggles.
  function automatic in_item_t gain_req(int src, int snk, logic [GAIN_BITS-1:0] g, bit fe);
    in_item_t r;
    r.cmd          = CMD_GAIN;
    r.source_index = src[SRC_W-1:0];
    r.sink_index   = snk[SNK_W-1:0];
    r.gain_value   = g;
    r.sample_value = SAMPLE_BITS'($urandom);
    r.frame_end    = fe;
    return r;
  endfunction

  function automatic in_item_t sample_req(int src, logic [SAMPLE_BITS-1:0] s, bit fe);
    in_item_t r;
    r.cmd          = CMD_SAMPLE;
    r.source_index = src[SRC_W-1:0];
    r.sink_index   = SNK_W'($urandom);
    r.gain_value   = GAIN_BITS'($urandom);
    r.sample_value = s;
    r.frame_end    = fe;
    return r;
  endfunction

  // Moderate gains and samples keep most mixes inside the output range;
  // the extremes and full-range values drive saturation.
  function automatic logic [GAIN_BITS-1:0] pick_gain();
    int v;
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return GAIN_BITS'($urandom);
      default: begin
        v = int'($urandom_range(0, 8192)) - 4096;
        return v[GAIN_BITS-1:0];
      end
    endcase
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    int v;
    case ($urandom_range(0, 7))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2, 3: return SAMPLE_BITS'($urandom);
      default: begin
        v = int'($urandom_range(0, 131072)) - 65536;
        return v[SAMPLE_BITS-1:0];
      end
    endcase
  endfunction

  // Mostly active sources, so that samples reach the MAC path; now and then
  // any source, which may be inactive and then only counts for its frame end.
  function automatic int pick_source();
    int n;
    n = board.live_sources();
    if (n == 0 || $urandom_range(0, 9) >= 8) begin
      return $urandom_range(0, 7);
    end
    return $urandom_range(0, n - 1);
  endfunction

  initial begin : stimulus
    int       sent;
    int       len;
    bit       fe;
    in_item_t req;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, reset counts of eight sources and eight sinks.
    // A gain write that carries a frame end must only write the gain.
    offer(gain_req(0, 0, 16'h7FFF, 1'b1));
    offer(gain_req(0, 1, 16'h8000, 1'b0));
    offer(gain_req(0, 2, 16'h0001, 1'b0));
    offer(gain_req(0, 3, 16'hFFFF, 1'b0));
    offer(gain_req(7, 7, 16'h1000, 1'b0));
    offer(gain_req(7, 0, 16'hF000, 1'b0));
    offer(sample_req(0, 24'h7FFFFF, 1'b0));
    offer(sample_req(0, 24'h800000, 1'b0));
    offer(sample_req(7, 24'd2048, 1'b1));
    // Rounding at exactly half a step in both directions, then just past it.
    offer(sample_req(0, 24'd2048, 1'b1));
    offer(sample_req(0, -24'sd2049, 1'b1));
    // Two full-scale products push sinks 0 and 1 past the output range.
    offer(sample_req(0, 24'h7FFFFF, 1'b0));
    offer(sample_req(0, 24'h7FFFFF, 1'b1));
    // A source whose gains are all still zero.
    offer(sample_req(5, 24'h123456, 1'b1));

    // A frame end on an inactive source still emits and clears the frame.
    settle();
    set_counts(4'd1, 4'd3);
    offer(sample_req(0, 24'd4096, 1'b0));
    offer(sample_req(7, 24'd12345, 1'b1));

    // With no active sinks a frame end emits nothing but still clears.
    settle();
    set_counts(4'd8, 4'd8);
    offer(sample_req(0, 24'd100000, 1'b0));
    settle();
    set_reg(CFG_ACTIVE_SINKS, 4'd0);
    offer(sample_req(0, 24'd5, 1'b1));

    // Counts above the matrix size clamp to it; undecoded indexes do nothing.
    settle();
    set_counts(4'd15, 4'd15);
    set_reg(CFG_IDX_SPARE_A, 4'd3);
    set_reg(CFG_IDX_SPARE_B, 4'd1);
    offer(sample_req(7, -24'sd5000, 1'b1));

    // With no active sources nothing contributes.
    settle();
    set_reg(CFG_ACTIVE_SOURCES, 4'd0);
    offer(sample_req(0, 24'd777, 1'b1));

    // Accumulator overflow: one long frame of full-scale products, positive
    // on even sinks and negative on odd sinks, runs every accumulator into
    // its 48-bit limit. A wrapped accumulator would flip the output sign.
    settle();
    set_counts(4'd8, 4'd8);
    for (int k = 0; k < MIX_SINKS; k++) begin
      offer(gain_req(0, k, (k % 2 == 0) ? 16'h8000 : 16'h7FFF, 1'b0));
    end
    for (int i = 0; i < OVERFLOW_SAMPLES; i++) begin
      offer(sample_req(0, 24'h800000, 1'b0));
    end
    offer(sample_req(0, 24'h7FFFFF, 1'b1));

    // Random part: short frames of samples with gain writes mixed in, run
    // under several channel counts. Now and then a frame ends without its
    // frame end, and a gain write carries a stray one.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      case (ph)
        0: set_counts(4'd8, 4'd8);
        1: set_counts(4'd1, 4'd1);
        2: set_counts(4'd15, 4'd8);
        3: set_counts(4'd0, 4'd5);
        4: set_counts(4'd5, 4'd3);
        default: set_counts(CFG_W'($urandom), CFG_W'($urandom));
      endcase
      // The last phase runs back to back on both sides.
      if (ph == RANDOM_PHASES - 1) calm = 1'b1;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 4) == 0) begin
            req = gain_req($urandom_range(0, 7), $urandom_range(0, 7), pick_gain(),
                           $urandom_range(0, 3) == 0);
          end else begin
            fe  = (i == len - 1) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0);
            req = sample_req(pick_source(), pick_sample(), fe);
          end
          offer(req);
          sent++;
        end
      end
    end

    // Close any open frame so that its sums come out and get checked.
    offer(sample_req(pick_source(), pick_sample(), 1'b1));
    settle();

    if (board.mismatches == 0) begin
      $display("audio_matrix_mixer regression: pass");
    end else begin
      $display("audio_matrix_mixer regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, even with every gap and stall
  // at its longest.
  initial begin
    #20_000_000;
    $display("audio_matrix_mixer regression: fail");
    $finish;
  end

endmodule
